### hw/rtl/hsfc_pkg.sv
// Shared types, constants and functions for the humidity sensor frame checker.
// Holds the CRC-8 byte function, the status codes and the conversion constants.
// No dependencies.
package hsfc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam int unsigned RAW_W = 16;
  localparam int unsigned HUND_W = 15;
  localparam logic [14:0] TEMP_SCALE = 15'd17525;
  localparam logic [13:0] HUM_SCALE = 14'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
  localparam logic signed [15:0] HUM_OFFSET = 16'sd600;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUS_FAIL = 2'd1,
    STATUS_CRC_FAIL = 2'd2
  } status_t;

  typedef logic signed [HUND_W-1:0] hundredths_t;
  typedef logic [RAW_W-1:0] raw_t;

  typedef struct packed {
    status_t status;
    logic    store;
  } check_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/hsfc_if.sv
// Valid/ready channel interfaces for sensor frames and conversion results.
// No dependencies.
interface hsfc_in_if;
  logic       valid;
  logic       ready;
  logic       measure_kind;
  logic       transfer_ok;
  logic [7:0] value_high;
  logic [7:0] value_low;
  logic [7:0] check_byte;
  logic [7:0] extra_temp_high;
  logic [7:0] extra_temp_low;

  modport source(output valid, measure_kind, transfer_ok, value_high, value_low,
                 check_byte, extra_temp_high, extra_temp_low, input ready);
  modport sink(input valid, measure_kind, transfer_ok, value_high, value_low,
               check_byte, extra_temp_high, extra_temp_low, output ready);
endinterface

interface hsfc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               result_kind;
  logic signed [14:0] temperature_hundredths;
  logic signed [14:0] humidity_hundredths;

  modport source(output valid, status, result_kind, temperature_hundredths,
                 humidity_hundredths, input ready);
  modport sink(input valid, status, result_kind, temperature_hundredths,
               humidity_hundredths, output ready);
endinterface

### hw/rtl/hsfc_frame_check.sv
// Bus status and CRC-8 check of one registered sensor frame.
// Depends on hsfc_pkg for crc8_byte and the status codes.
module hsfc_frame_check
  import hsfc_pkg::*;
(
  input  logic       transfer_ok,
  input  logic [7:0] value_high,
  input  logic [7:0] value_low,
  input  logic [7:0] check_byte,
  output check_t     check
);

  logic [7:0] crc;

  assign crc = crc8_byte(crc8_byte(8'h00, value_high), value_low);

  always_comb begin
    priority if (!transfer_ok) begin
      check.status = STATUS_BUS_FAIL;
      check.store  = 1'b0;
    end else if (crc != check_byte) begin
      check.status = STATUS_CRC_FAIL;
      check.store  = 1'b0;
    end else begin
      check.status = STATUS_OK;
      check.store  = 1'b1;
    end
  end

endmodule

### hw/rtl/hsfc_convert.sv
// Fixed-point conversion of raw readings to hundredths of a degree and of a percent.
// Depends on hsfc_pkg for the scale and offset constants.
module hsfc_convert
  import hsfc_pkg::*;
(
  input  logic        measure_kind,
  input  raw_t        value_raw,
  input  raw_t        extra_raw,
  output hundredths_t temperature,
  output hundredths_t humidity
);

  raw_t               temp_raw;
  logic [30:0]        temp_prod;
  logic [29:0]        hum_prod;
  logic signed [15:0] temp_wide;
  logic signed [15:0] hum_wide;

  // A humidity frame carries its temperature in the extra bytes.
  assign temp_raw  = measure_kind ? extra_raw : value_raw;
  assign temp_prod = 31'(TEMP_SCALE) * 31'(temp_raw);
  assign hum_prod  = 30'(HUM_SCALE) * 30'(value_raw);

  assign temp_wide = signed'({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
  assign hum_wide  = signed'({2'b00, hum_prod[29:16]}) - HUM_OFFSET;

  assign temperature = temp_wide[HUND_W-1:0];
  assign humidity    = hum_wide[HUND_W-1:0];

endmodule

### hw/rtl/humidity_sensor_frame_check_convert.sv
// Top level of the sensor frame checker: input register, check and conversion, result register.
// Depends on hsfc_pkg, hsfc_if, hsfc_frame_check and hsfc_convert.
//
//   channel  role    contents
//   frame    sink    kind, bus flag, data bytes, CRC byte, extra temperature bytes
//   result   source  status, kind, last good temperature and humidity
//
// A frame passes from acceptance through the input register and then the result register
// to its result; one frame is taken every cycle while the result is not stalled.
// The kept temperature and humidity are updated as a good frame passes into the result
// register (humidity only by a humidity frame), so the next frame sees them at once.
// A stalled result holds the result register; the input register still fills behind it.
// Reset clears the valid flags and the kept values to zero.
module humidity_sensor_frame_check_convert
  import hsfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hsfc_in_if.sink    frame,
  hsfc_out_if.source result
);

  logic        s1_valid;
  logic        s1_kind;
  logic        s1_ok;
  raw_t        s1_value;
  raw_t        s1_extra;
  logic [7:0]  s1_check;
  logic        s1_advance;
  check_t      check;
  hundredths_t conv_temp;
  hundredths_t conv_hum;
  hundredths_t kept_temp;
  hundredths_t kept_hum;
  hundredths_t kept_temp_next;
  hundredths_t kept_hum_next;
  logic        out_valid;

  assign s1_advance  = !out_valid || result.ready;
  assign frame.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s1_kind  <= frame.measure_kind;
      s1_ok    <= frame.transfer_ok;
      s1_value <= {frame.value_high, frame.value_low};
      s1_extra <= {frame.extra_temp_high, frame.extra_temp_low};
      s1_check <= frame.check_byte;
    end
  end

  hsfc_frame_check u_check (
    .transfer_ok (s1_ok),
    .value_high  (s1_value[15:8]),
    .value_low   (s1_value[7:0]),
    .check_byte  (s1_check),
    .check       (check)
  );

  hsfc_convert u_convert (
    .measure_kind (s1_kind),
    .value_raw    (s1_value),
    .extra_raw    (s1_extra),
    .temperature  (conv_temp),
    .humidity     (conv_hum)
  );

  always_comb begin
    kept_temp_next = kept_temp;
    kept_hum_next  = kept_hum;
    if (check.store) begin
      kept_temp_next = conv_temp;
      if (s1_kind) begin
        kept_hum_next = conv_hum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_temp <= '0;
      kept_hum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && s1_advance) begin
        kept_temp <= kept_temp_next;
        kept_hum  <= kept_hum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      result.status                 <= check.status;
      result.result_kind            <= s1_kind;
      result.temperature_hundredths <= kept_temp_next;
      result.humidity_hundredths    <= kept_hum_next;
    end
  end

  assign result.valid = out_valid;

  a_kept_hold_on_fail: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance && !check.store)
      |=> (kept_temp == $past(kept_temp) && kept_hum == $past(kept_hum)))
    else $error("kept values changed on a rejected frame");

  a_hum_hold_on_temp: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance && !s1_kind) |=> (kept_hum == $past(kept_hum)))
    else $error("humidity changed on a temperature frame");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance) |=> out_valid)
    else $error("frame lost between input and result register");

  a_result_matches_kept: assert property (@(posedge clk) disable iff (rst)
    $past(s1_valid && s1_advance)
      |-> (result.temperature_hundredths == kept_temp
           && result.humidity_hundredths == kept_hum))
    else $error("result does not show the kept values");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.status[1] && result.status[0]))
    else $error("undefined status code on the result");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the sensor frame checker: sends frames over the valid/ready
// channel and checks every result against an in-bench model of the CRC check and conversion.
// Depends on hsfc_pkg, hsfc_if and humidity_sensor_frame_check_convert.
module tb;
  import hsfc_pkg::*;

  localparam int RANDOM_FRAMES = 2000;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chk;
    logic [7:0] xhi;
    logic [7:0] xlo;
  } sensor_frame_t;

  typedef struct packed {
    status_t     status;
    logic        kind;
    hundredths_t temp;
    hundredths_t hum;
  } reading_t;

  class reading_board;
    hundredths_t kept_temp;
    hundredths_t kept_hum;
    reading_t    readings_due[$];
    int          errors;
    int          frames_seen;
    int          readings_checked;
    int          status_seen[3];

    function new();
      kept_temp = '0;
      kept_hum = '0;
      errors = 0;
      frames_seen = 0;
      readings_checked = 0;
      status_seen = '{0, 0, 0};
    endfunction

    static function logic [7:0] crc_over(logic [7:0] hi, logic [7:0] lo);
      logic [15:0] bits;
      logic [7:0]  crc;
      bits = {hi, lo};
      crc = 8'h00;
      for (int i = 15; i >= 0; i--) begin
        if (crc[7] ^ bits[i]) begin
          crc = {crc[6:0], 1'b0} ^ CRC_POLY;
        end else begin
          crc = {crc[6:0], 1'b0};
        end
      end
      return crc;
    endfunction

    static function hundredths_t scale_raw(raw_t raw, int unsigned scale, int offset);
      logic [31:0] product;
      product = scale * raw;
      return hundredths_t'(int'(product[31:16]) - offset);
    endfunction

    function void note_frame(sensor_frame_t f);
      reading_t r;
      frames_seen++;
      if (!f.ok) begin
        r.status = STATUS_BUS_FAIL;
      end else if (crc_over(f.hi, f.lo) != f.chk) begin
        r.status = STATUS_CRC_FAIL;
      end else begin
        r.status = STATUS_OK;
        if (!f.kind) begin
          kept_temp = scale_raw({f.hi, f.lo}, TEMP_SCALE, TEMP_OFFSET);
        end else begin
          kept_temp = scale_raw({f.xhi, f.xlo}, TEMP_SCALE, TEMP_OFFSET);
          kept_hum = scale_raw({f.hi, f.lo}, HUM_SCALE, HUM_OFFSET);
        end
      end
      r.kind = f.kind;
      r.temp = kept_temp;
      r.hum = kept_hum;
      readings_due.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
               $time, readings_checked, field, want, got);
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: result with no frame outstanding: status %0d kind %0d", $time,
                 int'(got.status), got.kind);
        return;
      end
      want = readings_due.pop_front();
      if (got.status !== want.status) report("status", int'(want.status), int'(got.status));
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.temp !== want.temp) report("temperature", want.temp, got.temp);
      if (got.hum !== want.hum) report("humidity", want.hum, got.hum);
      if (want.status <= STATUS_CRC_FAIL) status_seen[want.status]++;
      readings_checked++;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic steady;

  hsfc_in_if  frame_ch();
  hsfc_out_if result_ch();

  reading_board book = new();

  humidity_sensor_frame_check_convert dut (
    .clk(clk),
    .rst(rst),
    .frame(frame_ch),
    .result(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_frame(input logic kind, input logic ok, input logic [7:0] hi,
                            input logic [7:0] lo, input logic [7:0] chk,
                            input logic [7:0] xhi, input logic [7:0] xlo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.measure_kind <= kind;
    frame_ch.transfer_ok <= ok;
    frame_ch.value_high <= hi;
    frame_ch.value_low <= lo;
    frame_ch.check_byte <= chk;
    frame_ch.extra_temp_high <= xhi;
    frame_ch.extra_temp_low <= xlo;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    book.note_frame('{kind, ok, hi, lo, chk, xhi, xlo});
  endtask

  task automatic send_good(input logic kind, input logic [15:0] raw, input logic [15:0] xraw);
    send_frame(kind, 1'b1, raw[15:8], raw[7:0], reading_board::crc_over(raw[15:8], raw[7:0]),
               xraw[15:8], xraw[7:0]);
  endtask

  // The receiver stalls at random, except during the steady stretches.
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall == 0) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reading_t got;
    if (result_ch.valid && result_ch.ready) begin
      got.status = status_t'(result_ch.status);
      got.kind = result_ch.result_kind;
      got.temp = result_ch.temperature_hundredths;
      got.hum = result_ch.humidity_hundredths;
      book.check_result(got);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no request accepted for %0d cycles, %0d results outstanding", $time,
             IDLE_LIMIT, book.pending());
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int          roll;
    logic [15:0] raw;
    logic [15:0] xraw;
    logic [7:0]  chk;
    logic        kind;
    steady = 1'b0;
    rst <= 1'b1;
    frame_ch.valid <= 1'b0;
    frame_ch.measure_kind <= 1'b0;
    frame_ch.transfer_ok <= 1'b0;
    frame_ch.value_high <= 8'h00;
    frame_ch.value_low <= 8'h00;
    frame_ch.check_byte <= 8'h00;
    frame_ch.extra_temp_high <= 8'h00;
    frame_ch.extra_temp_low <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Failed transfers and bad checksums before any good frame must report zeros.
    send_frame(1'b0, 1'b0, 8'h12, 8'h34, reading_board::crc_over(8'h12, 8'h34),
               8'h00, 8'h00);
    send_frame(1'b1, 1'b1, 8'h55, 8'hAA, reading_board::crc_over(8'h55, 8'hAA) ^ 8'h01,
               8'hFF, 8'hFF);
    send_good(1'b0, 16'h0000, 16'hFFFF);
    send_good(1'b0, 16'hFFFF, 16'h0000);
    send_good(1'b1, 16'h0000, 16'hFFFF);
    send_good(1'b1, 16'hFFFF, 16'h0000);
    send_good(1'b0, 16'h8000, 16'h1234);
    send_good(1'b1, 16'h7FFF, 16'h8000);
    send_frame(1'b0, 1'b1, 8'h80, 8'h00, reading_board::crc_over(8'h80, 8'h00) ^ 8'h80,
               8'h00, 8'h00);
    send_frame(1'b1, 1'b1, 8'h66, 8'h66, 8'h00, 8'hAB, 8'hCD);
    send_frame(1'b0, 1'b1, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00);
    send_frame(1'b1, 1'b0, 8'hAB, 8'hCD, reading_board::crc_over(8'hAB, 8'hCD),
               8'h12, 8'h34);
    send_frame(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_good(1'b0, 16'h683A, 16'hFFFF);
    send_good(1'b1, 16'h5A5A, 16'hA5A5);
    send_good(1'b0, 16'h0001, 16'h0000);
    send_good(1'b1, 16'hFFFE, 16'h0001);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 250 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      raw = 16'($urandom);
      xraw = 16'($urandom);
      if ($urandom_range(0, 9) == 0) raw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(0, 9) == 0) xraw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      chk = reading_board::crc_over(raw[15:8], raw[7:0]);
      if (roll < 12) begin
        send_frame(kind, 1'b0, raw[15:8], raw[7:0], $urandom_range(0, 1) ? chk : 8'($urandom),
                   xraw[15:8], xraw[7:0]);
      end else if (roll < 27) begin
        send_frame(kind, 1'b1, raw[15:8], raw[7:0], 8'($urandom), xraw[15:8], xraw[7:0]);
      end else begin
        send_good(kind, raw, xraw);
      end
    end
    frame_ch.valid <= 1'b0;
    steady = 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d frames sent, %0d results checked", book.frames_seen,
             book.readings_checked);
    $display("tb: stored %0d, transfer failed %0d, checksum mismatch %0d, mismatches %0d",
             book.status_seen[STATUS_OK], book.status_seen[STATUS_BUS_FAIL],
             book.status_seen[STATUS_CRC_FAIL], book.errors);
    if (book.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/hsfc_pkg.sv
hw/rtl/hsfc_if.sv
hw/rtl/hsfc_frame_check.sv
hw/rtl/hsfc_convert.sv
hw/rtl/humidity_sensor_frame_check_convert.sv
tb/sv/tb.sv
